// ===== rtl/gfpr_pkg.sv =====
package gfpr_pkg;

  // default degree of the divisor
  localparam int unsigned REMAINDER_BITS_DEFAULT = 32;

  // fixed field widths
  localparam int unsigned DataW = 8;
  localparam int unsigned RemW  = 32;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDivisor   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegByteOrder = 2'd1;

  // byte order codes
  localparam logic OrderFirstMsb = 1'b0;
  localparam logic OrderLastMsb  = 1'b1;

  // register reset values
  localparam logic [CfgW-1:0] DivisorReset = 32'h04C1_1DB7;
  localparam logic            ByteOrderReset = OrderLastMsb;

endpackage

// ===== rtl/gfpr_if.sv =====
interface gfpr_in_if;
  logic                         valid;
  logic                         ready;
  logic [gfpr_pkg::DataW-1:0]   data_byte;
  logic                         last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gfpr_out_if;
  logic                        valid;
  logic                        ready;
  logic [gfpr_pkg::RemW-1:0]   remainder;

  modport source (output valid, output remainder, input ready);
  modport sink   (input valid, input remainder, output ready);
endinterface

// ===== rtl/gfpr_fold.sv =====
module gfpr_fold #(
  parameter int unsigned REMAINDER_BITS = gfpr_pkg::REMAINDER_BITS_DEFAULT
) (
  input  logic [REMAINDER_BITS-1:0]  rem_i,
  input  logic [REMAINDER_BITS-1:0]  pow_i,
  input  logic [REMAINDER_BITS-1:0]  divisor_i,
  input  logic [gfpr_pkg::DataW-1:0] data_i,
  input  logic                       order_i,
  output logic [REMAINDER_BITS-1:0]  rem_o,
  output logic [REMAINDER_BITS-1:0]  pow_o
);

  logic [REMAINDER_BITS-1:0] horner;
  logic [REMAINDER_BITS-1:0] acc;
  logic [REMAINDER_BITS-1:0] pow_next;

  // eight shift-xor steps each, three independent chains
  always_comb begin
    horner   = rem_i;
    acc      = '0;
    pow_next = pow_i;
    for (int i = gfpr_pkg::DataW - 1; i >= 0; i--) begin
      horner = {horner[REMAINDER_BITS-2:0], data_i[i]}
               ^ (horner[REMAINDER_BITS-1] ? divisor_i : '0);
      acc    = {acc[REMAINDER_BITS-2:0], 1'b0}
               ^ (acc[REMAINDER_BITS-1] ? divisor_i : '0)
               ^ (data_i[i] ? pow_i : '0);
      pow_next = {pow_next[REMAINDER_BITS-2:0], 1'b0}
                 ^ (pow_next[REMAINDER_BITS-1] ? divisor_i : '0);
    end
  end

  always_comb begin
    unique case (order_i)
      gfpr_pkg::OrderFirstMsb: begin
        rem_o = horner;
        pow_o = pow_i;
      end
      default: begin
        rem_o = rem_i ^ acc;
        pow_o = pow_next;
      end
    endcase
  end

endmodule

// ===== rtl/gf2_polynomial_remainder_top.sv =====
// GF(2) remainder of a byte message divided by a divisor of degree REMAINDER_BITS whose
// leading term is implied; no augmentation, no initial value, no final xor. Bytes
// arrive one per in_chan transaction, last_byte closes the message and yields one
// out_chan transaction carrying the remainder (bits above REMAINDER_BITS are zero),
// after which the state clears for the next message. byte_order 0 reads the first
// byte as most significant (horner fold), 1 reads the last byte as most significant
// (running power of x^8). One byte is taken every cycle unless the input stalls: an
// accepted byte waits in the input register while the eight-step fold logic runs,
// then goes into the state and result registers, so a remainder is presented from
// the result register after its last byte has passed the input register. The input
// stalls only while a last byte sits in the input register and the result register
// still holds a remainder that is not taken. Configure only while no message is open.
module gf2_polynomial_remainder_top #(
  parameter int unsigned REMAINDER_BITS = gfpr_pkg::REMAINDER_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gfpr_in_if.sink                       in_chan,
  gfpr_out_if.source                    out_chan,
  input  logic                          cfg_we_i,
  input  logic [gfpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gfpr_pkg::CfgW-1:0]     cfg_wdata_i
);

  // configuration registers
  logic [gfpr_pkg::CfgW-1:0] divisor_q;
  logic                      order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= gfpr_pkg::DivisorReset;
      order_q   <= gfpr_pkg::ByteOrderReset;
    end else if (cfg_we_i) begin
      // indexes beyond the register list are ignored
      unique case (cfg_idx_i)
        gfpr_pkg::RegDivisor:   divisor_q <= cfg_wdata_i;
        gfpr_pkg::RegByteOrder: order_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic                       in_valid_q;
  logic [gfpr_pkg::DataW-1:0] in_data_q;
  logic                       in_last_q;
  logic                       out_valid_q;
  logic                       out_free;
  logic                       advance;
  logic                       in_take;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_chan.ready;
  // a non-final byte only updates state; a final byte needs the result slot
  assign advance  = in_valid_q && (!in_last_q || out_free);
  assign in_chan.ready = !in_valid_q || advance;
  assign in_take  = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_chan.data_byte;
      in_last_q <= in_chan.last_byte;
    end
  end

  // running state of the open message
  logic [REMAINDER_BITS-1:0] rem_q;
  logic [REMAINDER_BITS-1:0] pow_q;
  logic [REMAINDER_BITS-1:0] rem_d;
  logic [REMAINDER_BITS-1:0] pow_d;

  gfpr_fold #(
    .REMAINDER_BITS(REMAINDER_BITS)
  ) u_fold (
    .rem_i    (rem_q),
    .pow_i    (pow_q),
    .divisor_i(divisor_q[REMAINDER_BITS-1:0]),
    .data_i   (in_data_q),
    .order_i  (order_q),
    .rem_o    (rem_d),
    .pow_o    (pow_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      pow_q <= REMAINDER_BITS'(1);
    end else if (advance) begin
      if (in_last_q) begin
        // message closed, back to empty polynomial and x^0
        rem_q <= '0;
        pow_q <= REMAINDER_BITS'(1);
      end else begin
        rem_q <= rem_d;
        pow_q <= pow_d;
      end
    end
  end

  // result register
  logic [gfpr_pkg::RemW-1:0] out_rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_rem_q <= gfpr_pkg::RemW'(rem_d);
    end
  end

  assign out_chan.valid     = out_valid_q;
  assign out_chan.remainder = out_rem_q;

endmodule
